/* design/ssi_pkg.sv */
package ssi_pkg;

	localparam int COORD_BITS_DEF = 31;

	typedef struct packed {
		logic valid;
		logic hit;
	} ssi_ctl_t;

endpackage

/* design/ssi_cross.sv */
module ssi_cross #(
	parameter int W = ssi_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [W-1:0]   ax,
	input  logic signed [W-1:0]   ay,
	input  logic signed [W-1:0]   bx,
	input  logic signed [W-1:0]   by,
	input  logic signed [W-1:0]   cx,
	input  logic signed [W-1:0]   cy,
	input  logic signed [W-1:0]   ex,
	input  logic signed [W-1:0]   ey,
	output logic                  out_valid,
	output logic signed [W-1:0]   out_ax,
	output logic signed [W-1:0]   out_ay,
	output logic signed [W:0]     out_v1x,
	output logic signed [W:0]     out_v1y,
	output logic signed [2*W+1:0] denom,
	output logic signed [2*W+1:0] na,
	output logic signed [2*W+1:0] nb
);
	import ssi_pkg::*;

	localparam int DW = W + 1;
	localparam int CW = 2 * W + 2;

	logic                 valid_s1;
	logic signed [W-1:0]  ax_s1, ay_s1;
	logic signed [DW-1:0] v1x_s1, v1y_s1, v2x_s1, v2y_s1, dx_s1, dy_s1;

	logic                 valid_s2;
	logic signed [W-1:0]  ax_s2, ay_s2;
	logic signed [DW-1:0] v1x_s2, v1y_s2;
	logic signed [CW-1:0] p_d0_s2, p_d1_s2, p_a0_s2, p_a1_s2, p_b0_s2, p_b1_s2;

	logic                 valid_s3;
	logic signed [W-1:0]  ax_s3, ay_s3;
	logic signed [DW-1:0] v1x_s3, v1y_s3;
	logic signed [CW-1:0] denom_s3, na_s3, nb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= ax;
		ay_s1  <= ay;
		v1x_s1 <= DW'(bx) - DW'(ax);
		v1y_s1 <= DW'(by) - DW'(ay);
		v2x_s1 <= DW'(ex) - DW'(cx);
		v2y_s1 <= DW'(ey) - DW'(cy);
		dx_s1  <= DW'(ax) - DW'(cx);
		dy_s1  <= DW'(ay) - DW'(cy);

		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		v1x_s2  <= v1x_s1;
		v1y_s2  <= v1y_s1;
		p_d0_s2 <= CW'(v1x_s1) * CW'(v2y_s1);
		p_d1_s2 <= CW'(v1y_s1) * CW'(v2x_s1);
		p_a0_s2 <= CW'(v2x_s1) * CW'(dy_s1);
		p_a1_s2 <= CW'(v2y_s1) * CW'(dx_s1);
		p_b0_s2 <= CW'(v1x_s1) * CW'(dy_s1);
		p_b1_s2 <= CW'(v1y_s1) * CW'(dx_s1);

		ax_s3    <= ax_s2;
		ay_s3    <= ay_s2;
		v1x_s3   <= v1x_s2;
		v1y_s3   <= v1y_s2;
		denom_s3 <= p_d0_s2 - p_d1_s2;
		na_s3    <= p_a0_s2 - p_a1_s2;
		nb_s3    <= p_b0_s2 - p_b1_s2;
	end

	assign out_valid = valid_s3;
	assign out_ax    = ax_s3;
	assign out_ay    = ay_s3;
	assign out_v1x   = v1x_s3;
	assign out_v1y   = v1y_s3;
	assign denom     = denom_s3;
	assign na        = na_s3;
	assign nb        = nb_s3;

endmodule

/* design/ssi_div.sv */
module ssi_div #(
	parameter int W   = ssi_pkg::COORD_BITS_DEF,
	parameter int SBW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [3*W:0]     num,
	input  logic [2*W+1:0]   den,
	input  logic [SBW-1:0]   sb_in,
	output logic             out_valid,
	output logic [W-1:0]     quo,
	output logic             rem_nz,
	output logic [SBW-1:0]   sb_out
);
	import ssi_pkg::*;

	localparam int RW = 2 * W + 2;

	logic           vld_s [W+1];
	logic [RW-1:0]  rem_s [W+1];
	logic [W-1:0]   nlo_s [W+1];
	logic [W-1:0]   quo_s [W+1];
	logic [RW-1:0]  den_s [W+1];
	logic [SBW-1:0] sb_s  [W+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = {1'b0, num[3*W:W]};
	assign nlo_s[0] = num[W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign sb_s[0]  = sb_in;

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;

		assign trial = {rem_s[k][RW-2:0], nlo_s[k][W-1]};
		assign ge    = (trial >= den_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? (trial - den_s[k]) : trial;
			nlo_s[k+1] <= {nlo_s[k][W-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][W-2:0], ge};
			den_s[k+1] <= den_s[k];
			sb_s[k+1]  <= sb_s[k];
		end
	end

	assign out_valid = vld_s[W];
	assign quo       = quo_s[W];
	assign rem_nz    = |rem_s[W];
	assign sb_out    = sb_s[W];

endmodule

/* design/segment_segment_intersection.sv */
// Channel   Ports                                   Handshake
// input     first_*, second_* (ax, ay, bx, by)      start high while busy low
// result    hit, point_x, point_y                   done high for one cycle
//
// One item is taken in every cycle; busy never rises.
// Each result passes through ssi_cross, stages s4 to s6, the restoring
// divider, which spends one stage per quotient bit, and the output register.
// Reset clears only the valid bits and the hit flags held with them, so items in flight are dropped.
// The receiver cannot stall, so no back-pressure is held anywhere.
module segment_segment_intersection #(
	parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] first_ax,
	input  logic signed [COORD_BITS-1:0] first_ay,
	input  logic signed [COORD_BITS-1:0] first_bx,
	input  logic signed [COORD_BITS-1:0] first_by,
	input  logic signed [COORD_BITS-1:0] second_ax,
	input  logic signed [COORD_BITS-1:0] second_ay,
	input  logic signed [COORD_BITS-1:0] second_bx,
	input  logic signed [COORD_BITS-1:0] second_by,
	output logic                         done,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y
);
	import ssi_pkg::*;

	localparam int W   = COORD_BITS;
	localparam int DW  = W + 1;
	localparam int CW  = 2 * W + 2;
	localparam int NW  = 3 * W + 1;
	localparam int SW  = W + 2;
	localparam int XSB = W + 2;
	localparam int YSB = W + 1;

	logic                 c_valid;
	logic signed [W-1:0]  c_ax, c_ay;
	logic signed [DW-1:0] c_v1x, c_v1y;
	logic signed [CW-1:0] c_denom, c_na, c_nb;

	logic                 valid_s4, nz_s4, negx_s4, negy_s4;
	logic signed [W-1:0]  ax_s4, ay_s4;
	logic [W-1:0]         magx_s4, magy_s4;
	logic signed [CW-1:0] denom_s4, na_s4, nb_s4;

	ssi_ctl_t             ctl_s5;
	logic                 negx_s5, negy_s5;
	logic signed [W-1:0]  ax_s5, ay_s5;
	logic [CW-1:0]        denom_s5;
	logic [2*W:0]         pxl_s5, pyl_s5;
	logic [2*W-1:0]       pxh_s5, pyh_s5;

	ssi_ctl_t             ctl_s6;
	logic                 negx_s6, negy_s6;
	logic signed [W-1:0]  ax_s6, ay_s6;
	logic [CW-1:0]        denom_s6;
	logic [NW-1:0]        nx_s6, ny_s6;

	logic                 dx_valid, dy_valid;
	logic [W-1:0]         qx, qy;
	logic                 rnzx, rnzy;
	logic [XSB-1:0]       sbx;
	logic [YSB-1:0]       sby;

	logic signed [SW-1:0] fx, fy, sx, sy;

	logic                 done_q, hit_q;
	logic signed [W-1:0]  point_x_q, point_y_q;

	assign busy = 1'b0;

	ssi_cross #(.W(W)) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.ax       (first_ax),
		.ay       (first_ay),
		.bx       (first_bx),
		.by       (first_by),
		.cx       (second_ax),
		.cy       (second_ay),
		.ex       (second_bx),
		.ey       (second_by),
		.out_valid(c_valid),
		.out_ax   (c_ax),
		.out_ay   (c_ay),
		.out_v1x  (c_v1x),
		.out_v1y  (c_v1y),
		.denom    (c_denom),
		.na       (c_na),
		.nb       (c_nb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			ctl_s5   <= '0;
			ctl_s6   <= '0;
		end else begin
			valid_s4     <= c_valid;
			ctl_s5.valid <= valid_s4;
			ctl_s5.hit   <= nz_s4 && !na_s4[CW-1] && !nb_s4[CW-1]
				&& (na_s4 <= denom_s4) && (nb_s4 <= denom_s4);
			ctl_s6       <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		ax_s4    <= c_ax;
		ay_s4    <= c_ay;
		nz_s4    <= (c_denom != '0);
		denom_s4 <= c_denom[CW-1] ? -c_denom : c_denom;
		na_s4    <= c_denom[CW-1] ? -c_na : c_na;
		nb_s4    <= c_denom[CW-1] ? -c_nb : c_nb;
		negx_s4  <= c_v1x[DW-1];
		negy_s4  <= c_v1y[DW-1];
		magx_s4  <= c_v1x[DW-1] ? W'(-c_v1x) : W'(c_v1x);
		magy_s4  <= c_v1y[DW-1] ? W'(-c_v1y) : W'(c_v1y);

		ax_s5    <= ax_s4;
		ay_s5    <= ay_s4;
		negx_s5  <= negx_s4;
		negy_s5  <= negy_s4;
		denom_s5 <= denom_s4;
		pxl_s5   <= (2*W+1)'(magx_s4) * (2*W+1)'(na_s4[W:0]);
		pyl_s5   <= (2*W+1)'(magy_s4) * (2*W+1)'(na_s4[W:0]);
		pxh_s5   <= (2*W)'(magx_s4) * (2*W)'(na_s4[2*W:W+1]);
		pyh_s5   <= (2*W)'(magy_s4) * (2*W)'(na_s4[2*W:W+1]);

		ax_s6    <= ax_s5;
		ay_s6    <= ay_s5;
		negx_s6  <= negx_s5;
		negy_s6  <= negy_s5;
		denom_s6 <= denom_s5;
		nx_s6    <= {pxh_s5, (W+1)'(0)} + NW'(pxl_s5);
		ny_s6    <= {pyh_s5, (W+1)'(0)} + NW'(pyl_s5);
	end

	ssi_div #(.W(W), .SBW(XSB)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ctl_s6.valid),
		.num      (nx_s6),
		.den      (denom_s6),
		.sb_in    ({ctl_s6.hit, negx_s6, ax_s6}),
		.out_valid(dx_valid),
		.quo      (qx),
		.rem_nz   (rnzx),
		.sb_out   (sbx)
	);

	ssi_div #(.W(W), .SBW(YSB)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ctl_s6.valid),
		.num      (ny_s6),
		.den      (denom_s6),
		.sb_in    ({negy_s6, ay_s6}),
		.out_valid(dy_valid),
		.quo      (qy),
		.rem_nz   (rnzy),
		.sb_out   (sby)
	);

	// The quotient is floored first, then nudged up when the true point is
	// negative and not whole, which gives truncation toward zero.
	always_comb begin
		fx = sbx[W] ? (-$signed({2'b00, qx}) - SW'(rnzx)) : $signed({2'b00, qx});
		sx = SW'(signed'(sbx[W-1:0])) + fx;
		if (sx[SW-1] && rnzx) begin
			sx = sx + SW'(1);
		end
		fy = sby[W] ? (-$signed({2'b00, qy}) - SW'(rnzy)) : $signed({2'b00, qy});
		sy = SW'(signed'(sby[W-1:0])) + fy;
		if (sy[SW-1] && rnzy) begin
			sy = sy + SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dx_valid && dy_valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q     <= sbx[W+1];
		point_x_q <= sbx[W+1] ? sx[W-1:0] : '0;
		point_y_q <= sbx[W+1] ? sy[W-1:0] : '0;
	end

	assign done    = done_q;
	assign hit     = hit_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;

endmodule
